>>> rtl/core/sliding_window_median_defines.svh
// assertion macros for the sliding window median block
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("swm: assertion failed");
// condition must never be seen out of reset
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("swm: forbidden condition seen");
`else
`define SWM_ASSERT(lbl, clk, rst_n, prop)
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/swm_pkg.sv
// shared types and constants of the sliding window median block
package swm_pkg;

  localparam int SampleW      = 32;
  localparam int WinLenW      = 7;
  localparam int MaxWindowDef = 64;
  localparam logic [WinLenW-1:0] WinLenRst = 7'd3;

  // what one sorted cell hands to its neighbors
  typedef struct packed {
    logic [SampleW-1:0] val;  // stored sample
    logic               gt;   // stored sample above the new sample, or empty cell
    logic               rm;   // cell sits at or right of the removed entry
  } swm_link_t;

endpackage

>>> rtl/core/swm_in_if.sv
// input request channel: one sample and its restart flag
interface swm_in_if import swm_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);

endinterface

>>> rtl/core/swm_out_if.sv
// output channel: lower median of the full window
interface swm_out_if import swm_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);

endinterface

>>> rtl/core/swm_cell.sv
// one cell of the sorted chain: removes the oldest entry and inserts the new sample
module swm_cell import swm_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [SampleW-1:0] old_i,
  input  logic               removing_i,
  input  logic               valid_i,
  input  swm_link_t          left_i,
  input  swm_link_t          right_i,
  output swm_link_t          link_o
);

  logic [SampleW-1:0] val_q;
  logic [SampleW-1:0] val_d;
  logic               gt;
  logic               rm;
  logic               ins_here;

  assign gt = !valid_i || ($signed(val_q) > $signed(sample_i));
  assign rm = removing_i && (!valid_i || ($signed(val_q) >= $signed(old_i)));

  // slot left of this one after removal holds our own value if it moved left
  assign ins_here = left_i.rm ? !gt : !left_i.gt;

  always_comb begin
    val_d = val_q;
    if (!rm) begin
      if (gt) begin
        val_d = left_i.gt ? left_i.val : sample_i;
      end
    end else begin
      if (!right_i.gt) begin
        val_d = right_i.val;
      end else if (ins_here) begin
        val_d = sample_i;
      end else begin
        val_d = left_i.rm ? val_q : left_i.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign link_o.val = val_q;
  assign link_o.gt  = gt;
  assign link_o.rm  = rm;

endmodule

>>> rtl/core/sliding_window_median.sv
// top level of the sliding window lower median filter
//
//  channel  | dir | payload                 | transfer
//  ---------+-----+-------------------------+---------------------------
//  in_i     | in  | sample[31:0], restart   | valid & ready
//  out_o    | out | median[31:0]            | valid & ready
//  cfg      | in  | cfg_wdata_i[6:0]        | cfg_we_i, no wait
//
// an item passes three steps: accept (arrival ring read of the oldest slot),
// update of the whole sorted cell chain at once, then load of the output register
// the sorted chain is a row of MAX_WINDOW cells, each comparing its value with
// the new and the removed sample and taking a value from itself or a neighbor
// reset clears control and the result; ring and cell values are undefined until written
// a request is taken only in idle; a result that is not yet taken holds the
// next item in the load step until the output register frees up
module sliding_window_median import swm_pkg::*; #(
  parameter int MAX_WINDOW = MaxWindowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WinLenW-1:0] cfg_wdata_i,
  swm_in_if.sink             in_i,
  swm_out_if.source          out_o
);

`include "sliding_window_median_defines.svh"

  localparam int CntW = $clog2(MAX_WINDOW + 1);
  localparam int PtrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SumW = CntW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD
  } state_e;

  state_e             state_q;
  logic [WinLenW-1:0] window_len_q;
  logic [CntW-1:0]    fill_q;
  logic [PtrW-1:0]    ptr_q;
  logic               emit_q;
  logic               out_valid_q;

  // payload registers
  logic [SampleW-1:0] sample_q;
  logic               restart_q;
  logic [SampleW-1:0] old_q;
  logic [SampleW-1:0] median_q;

  // arrival ring
  logic [SampleW-1:0] ring [MAX_WINDOW];

  // derived control
  logic [CntW-1:0]  w_eff;
  logic [PtrW-1:0]  mid_idx;
  logic [CntW-1:0]  fill_eff;
  logic [PtrW-1:0]  ptr_eff;
  logic             removing;
  logic [SumW-1:0]  slot_sum;
  logic [PtrW-1:0]  slot;
  logic [CntW-1:0]  fill_next;
  logic [PtrW-1:0]  ptr_next;
  logic [SumW-1:0]  ptr_inc;
  logic             in_acc;
  logic             out_free;

  // sorted chain
  swm_link_t        links [MAX_WINDOW];
  logic             cell_valid [MAX_WINDOW];
  swm_link_t        edge_left;
  swm_link_t        edge_right;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // zero acts as one, anything above the chain length is clipped
  always_comb begin
    if (window_len_q == '0) begin
      w_eff = CntW'(1);
    end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
      w_eff = CntW'(MAX_WINDOW);
    end else begin
      w_eff = CntW'(window_len_q);
    end
  end

  assign mid_idx = PtrW'((w_eff - CntW'(1)) >> 1);

  // restart empties the window before the sample goes in
  assign fill_eff = restart_q ? '0 : fill_q;
  assign ptr_eff  = restart_q ? '0 : ptr_q;
  assign removing = (fill_eff == w_eff);

  // write slot: next free slot while filling, oldest slot once full
  always_comb begin
    slot_sum = SumW'(ptr_eff) + SumW'(fill_eff);
    if (slot_sum >= SumW'(w_eff)) begin
      slot_sum = slot_sum - SumW'(w_eff);
    end
    slot = PtrW'(slot_sum);
  end

  always_comb begin
    ptr_inc   = SumW'(ptr_eff) + SumW'(1);
    fill_next = fill_eff;
    ptr_next  = ptr_eff;
    if (removing) begin
      ptr_next = (ptr_inc >= SumW'(w_eff)) ? '0 : PtrW'(ptr_inc);
    end else begin
      fill_next = fill_eff + CntW'(1);
    end
  end

  // chain ends: nothing removed or larger on the left, empty cells on the right
  assign edge_left  = '{val: '0, gt: 1'b0, rm: 1'b0};
  assign edge_right = '{val: '0, gt: 1'b1, rm: 1'b1};

  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
    swm_link_t left_link;
    swm_link_t right_link;

    assign cell_valid[gi] = (fill_eff > CntW'(gi));

    if (gi == 0) begin : g_first
      assign left_link = edge_left;
    end else begin : g_inner_l
      assign left_link = links[gi-1];
    end

    if (gi == MAX_WINDOW - 1) begin : g_last
      assign right_link = edge_right;
    end else begin : g_inner_r
      assign right_link = links[gi+1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (state_q == ST_UPDATE),
      .sample_i   (sample_q),
      .old_i      (old_q),
      .removing_i (removing),
      .valid_i    (cell_valid[gi]),
      .left_i     (left_link),
      .right_i    (right_link),
      .link_o     (links[gi])
    );
  end

  // control, state machine and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= WinLenRst;
      fill_q       <= '0;
      ptr_q        <= '0;
      emit_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      median_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          emit_q  <= (fill_next == w_eff);
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (!emit_q || out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // a new median may replace one that is taken in the same cycle
      if (state_q == ST_LOAD && emit_q && out_free) begin
        out_valid_q <= 1'b1;
        median_q    <= links[mid_idx].val;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // a window length write starts an empty window
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
        fill_q       <= '0;
        ptr_q        <= '0;
      end else if (state_q == ST_UPDATE) begin
        fill_q <= fill_next;
        ptr_q  <= ptr_next;
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q  <= in_i.sample;
      restart_q <= in_i.restart;
    end
  end

  // arrival ring: oldest slot read on accept, new sample written on update
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      old_q <= ring[ptr_q];
    end
    if (state_q == ST_UPDATE) begin
      ring[slot] <= sample_q;
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.median = median_q;

  // checks
  `SWM_ASSERT(a_fill_in_win, clk_i, rst_ni, fill_q <= w_eff)
  `SWM_ASSERT(a_ptr_in_win, clk_i, rst_ni, CntW'(ptr_q) < w_eff)
  `SWM_ASSERT(a_accept_updates, clk_i, rst_ni, in_acc |=> state_q == ST_UPDATE)
  `SWM_ASSERT(a_out_from_load, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_LOAD))
  `SWM_ASSERT_NEVER(a_load_lost, clk_i, rst_ni, state_q == ST_LOAD && $past(state_q == ST_IDLE))

endmodule
